@@ hw/rtl/aesp_pkg.sv @@
// ----------------------------------------------------------------------------
// ANSI escape parser package
// Shared codes, character constants and the controller/datapath bundles.
// ----------------------------------------------------------------------------
package aesp_pkg;

  localparam int unsigned ITEM_W = 6;

  // parser states
  localparam logic [2:0] PS_GROUND  = 3'd0;
  localparam logic [2:0] PS_ESC     = 3'd1;
  localparam logic [2:0] PS_CSI     = 3'd2;
  localparam logic [2:0] PS_OSC     = 3'd3;
  localparam logic [2:0] PS_OSC_ESC = 3'd4;
  localparam logic [2:0] PS_STR     = 3'd5;
  localparam logic [2:0] PS_STR_ESC = 3'd6;

  // result sequencer states
  localparam logic [1:0] SQ_IDLE = 2'd0;
  localparam logic [1:0] SQ_READ = 2'd1;
  localparam logic [1:0] SQ_LOAD = 2'd2;

  // result actions
  localparam logic [2:0] ACT_PRINT = 3'd0;
  localparam logic [2:0] ACT_EXEC  = 3'd1;
  localparam logic [2:0] ACT_CSI   = 3'd2;
  localparam logic [2:0] ACT_OSC   = 3'd3;
  localparam logic [2:0] ACT_DCS   = 3'd4;

  // characters
  localparam logic [7:0] CH_BEL    = 8'h07;
  localparam logic [7:0] CH_ESC    = 8'h1B;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_QMARK  = 8'h3F;
  localparam logic [7:0] CH_AT     = 8'h40;
  localparam logic [7:0] CH_DCS    = 8'h50;
  localparam logic [7:0] CH_SOS    = 8'h58;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_PM     = 8'h5E;
  localparam logic [7:0] CH_APC    = 8'h5F;
  localparam logic [7:0] CH_RIS    = 8'h63;
  localparam logic [7:0] CH_TILDE  = 8'h7E;
  localparam logic [7:0] CH_DEL    = 8'h7F;

  typedef struct packed {
    logic       clr_csi;
    logic       clr_text;
    logic       set_priv;
    logic       digit;
    logic       sep;
    logic       fin;
    logic       push;
    logic       single;
    logic [2:0] single_act;
    logic       run_start;
    logic       run_osc;
    logic       rd;
    logic       load_item;
  } ctrl_cmd_t;

  typedef struct packed {
    logic csi_empty;
    logic osc_empty;
    logic item_last;
    logic out_free;
  } dp_stat_t;

endpackage

@@ hw/rtl/aesp_if.sv @@
// ----------------------------------------------------------------------------
// ANSI escape parser channels
// Valid/ready channels for input bytes and parse results.
// ----------------------------------------------------------------------------
interface aesp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink (input valid, input in_byte, output ready);
endinterface

interface aesp_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  action;
  logic [7:0]  data_byte;
  logic        private_flag;
  logic [5:0]  item_index;
  logic [15:0] param_value;
  logic [5:0]  item_count;
  logic        last;

  modport source (
    output valid, output action, output data_byte, output private_flag,
    output item_index, output param_value, output item_count, output last,
    input ready
  );
  modport sink (
    input valid, input action, input data_byte, input private_flag,
    input item_index, input param_value, input item_count, input last,
    output ready
  );
endinterface

@@ hw/rtl/aesp_ctrl.sv @@
// ----------------------------------------------------------------------------
// ANSI escape parser controller
// Parser state machine and result run sequencer; drives datapath commands.
// ----------------------------------------------------------------------------
module aesp_ctrl import aesp_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic [7:0] in_byte_i,
  output logic       in_ready_o,
  input  dp_stat_t   stat_i,
  output ctrl_cmd_t  cmd_o
);

  logic [2:0] parse_q, parse_d;
  logic [1:0] seq_q, seq_d;
  logic       acc;
  logic [7:0] b;

  assign b          = in_byte_i;
  assign in_ready_o = (seq_q == SQ_IDLE) && stat_i.out_free;
  assign acc        = in_valid_i && in_ready_o;

  always_comb begin
    parse_d = parse_q;
    seq_d   = seq_q;
    cmd_o   = '0;

    if (acc) begin
      unique case (parse_q)
        PS_ESC: begin
          parse_d = PS_GROUND;
          if (b == CH_LBRACK) begin
            parse_d       = PS_CSI;
            cmd_o.clr_csi = 1'b1;
          end else if (b == CH_RBRACK) begin
            parse_d        = PS_OSC;
            cmd_o.clr_text = 1'b1;
          end else if (b == CH_DCS || b == CH_APC || b == CH_PM || b == CH_SOS) begin
            parse_d = PS_STR;
          end else if (b == CH_RIS || (b >= CH_AT && b <= CH_APC)) begin
            cmd_o.single     = 1'b1;
            cmd_o.single_act = ACT_EXEC;
          end
        end
        PS_CSI: begin
          if (b == CH_QMARK) begin
            cmd_o.set_priv = 1'b1;
          end else if (b >= CH_ZERO && b <= CH_NINE) begin
            cmd_o.digit = 1'b1;
          end else if (b == CH_SEMI) begin
            cmd_o.sep = 1'b1;
          end else if (b >= CH_SPACE && b <= CH_QMARK) begin
            parse_d = PS_CSI;
          end else if (b >= CH_AT && b <= CH_TILDE) begin
            parse_d   = PS_GROUND;
            cmd_o.fin = 1'b1;
            if (stat_i.csi_empty) begin
              cmd_o.single     = 1'b1;
              cmd_o.single_act = ACT_CSI;
            end else begin
              cmd_o.run_start = 1'b1;
              seq_d           = SQ_READ;
            end
          end else begin
            parse_d = PS_GROUND;
          end
        end
        PS_OSC, PS_OSC_ESC: begin
          parse_d = PS_GROUND;
          if ((parse_q == PS_OSC && b == CH_BEL) ||
              (parse_q == PS_OSC_ESC && b == CH_BSLASH)) begin
            if (stat_i.osc_empty) begin
              cmd_o.single     = 1'b1;
              cmd_o.single_act = ACT_OSC;
            end else begin
              cmd_o.run_start = 1'b1;
              cmd_o.run_osc   = 1'b1;
              seq_d           = SQ_READ;
            end
          end else if (parse_q == PS_OSC && b == CH_ESC) begin
            parse_d = PS_OSC_ESC;
          end else if (parse_q == PS_OSC) begin
            parse_d    = PS_OSC;
            cmd_o.push = 1'b1;
          end
        end
        PS_STR: begin
          if (b == CH_ESC) begin
            parse_d = PS_STR_ESC;
          end else if (b == CH_BEL) begin
            parse_d          = PS_GROUND;
            cmd_o.single     = 1'b1;
            cmd_o.single_act = ACT_DCS;
          end
        end
        PS_STR_ESC: begin
          parse_d = PS_GROUND;
          if (b == CH_BSLASH) begin
            cmd_o.single     = 1'b1;
            cmd_o.single_act = ACT_DCS;
          end
        end
        default: begin
          parse_d      = PS_GROUND;
          if (b == CH_ESC) begin
            parse_d = PS_ESC;
          end else if (b < CH_SPACE || b == CH_DEL) begin
            cmd_o.single     = 1'b1;
            cmd_o.single_act = ACT_EXEC;
          end else begin
            cmd_o.single     = 1'b1;
            cmd_o.single_act = ACT_PRINT;
          end
        end
      endcase
    end

    unique case (seq_q)
      SQ_READ: begin
        cmd_o.rd = 1'b1;
        seq_d    = SQ_LOAD;
      end
      SQ_LOAD: begin
        if (stat_i.out_free) begin
          cmd_o.load_item = 1'b1;
          seq_d           = stat_i.item_last ? SQ_IDLE : SQ_READ;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      parse_q <= PS_GROUND;
      seq_q   <= SQ_IDLE;
    end else begin
      parse_q <= parse_d;
      seq_q   <= seq_d;
    end
  end

endmodule

@@ hw/rtl/aesp_dp.sv @@
// ----------------------------------------------------------------------------
// ANSI escape parser datapath
// Parameter accumulator, parameter and text stores, output register.
// ----------------------------------------------------------------------------
module aesp_dp import aesp_pkg::*; #(
  parameter int unsigned MAX_PARAMS = 16,
  parameter int unsigned OSC_DEPTH  = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [7:0]  in_byte_i,
  input  ctrl_cmd_t   cmd_i,
  output dp_stat_t    stat_o,
  input  logic        out_ready_i,
  output logic        out_valid_o,
  output logic [2:0]  action_o,
  output logic [7:0]  data_byte_o,
  output logic        private_flag_o,
  output logic [5:0]  item_index_o,
  output logic [15:0] param_value_o,
  output logic [5:0]  item_count_o,
  output logic        last_o
);

  localparam int unsigned PCW = $clog2(MAX_PARAMS + 1);
  localparam int unsigned PIW = (MAX_PARAMS > 1) ? $clog2(MAX_PARAMS) : 1;
  localparam int unsigned TLW = $clog2(OSC_DEPTH);

  logic [15:0]       pmem [MAX_PARAMS];
  logic [7:0]        tmem [OSC_DEPTH];

  logic [PCW-1:0]    ptot_q, ptot_d;
  logic [15:0]       accum_q, accum_d;
  logic              seen_q, seen_d;
  logic              priv_q, priv_d;
  logic [TLW-1:0]    tlen_q, tlen_d;
  logic              pwr;
  logic [15:0]       pwdata;
  logic              twr;
  logic [19:0]       acc_sum;

  logic [ITEM_W-1:0] idx_q;
  logic              run_osc_q;
  logic [7:0]        fin_q;
  logic [15:0]       prd_q;
  logic [7:0]        trd_q;
  logic [ITEM_W-1:0] cnt;

  logic              out_valid_q;
  logic [2:0]        act_q;
  logic [7:0]        data_q;
  logic              oprv_q;
  logic [5:0]        oidx_q;
  logic [15:0]       oval_q;
  logic [5:0]        ocnt_q;
  logic              olast_q;

  assign acc_sum = {1'b0, accum_q, 3'b000} + {3'b000, accum_q, 1'b0}
                 + {16'd0, in_byte_i[3:0]};

  always_comb begin
    ptot_d  = ptot_q;
    accum_d = accum_q;
    seen_d  = seen_q;
    priv_d  = priv_q;
    tlen_d  = tlen_q;
    pwr     = 1'b0;
    pwdata  = accum_q;
    twr     = 1'b0;

    if (cmd_i.clr_csi) begin
      ptot_d  = '0;
      accum_d = '0;
      seen_d  = 1'b0;
      priv_d  = 1'b0;
      tlen_d  = '0;
    end
    if (cmd_i.clr_text) begin
      tlen_d = '0;
    end
    if (cmd_i.set_priv) begin
      priv_d = 1'b1;
    end
    if (cmd_i.digit) begin
      accum_d = (acc_sum[19:16] != 4'd0) ? 16'hFFFF : acc_sum[15:0];
      seen_d  = 1'b1;
    end
    if (cmd_i.sep || (cmd_i.fin && seen_q)) begin
      pwdata = seen_q ? accum_q : 16'd0;
      if (ptot_q < PCW'(MAX_PARAMS)) begin
        pwr    = 1'b1;
        ptot_d = ptot_q + PCW'(1);
      end
    end
    if (cmd_i.sep) begin
      accum_d = '0;
      seen_d  = 1'b0;
    end
    if (cmd_i.push && (tlen_q < TLW'(OSC_DEPTH - 1))) begin
      twr    = 1'b1;
      tlen_d = tlen_q + TLW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptot_q  <= '0;
      accum_q <= '0;
      seen_q  <= 1'b0;
      priv_q  <= 1'b0;
      tlen_q  <= '0;
    end else begin
      ptot_q  <= ptot_d;
      accum_q <= accum_d;
      seen_q  <= seen_d;
      priv_q  <= priv_d;
      tlen_q  <= tlen_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pwr) begin
      pmem[ptot_q[PIW-1:0]] <= pwdata;
    end
    if (cmd_i.rd) begin
      prd_q <= pmem[idx_q[PIW-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (twr) begin
      tmem[tlen_q] <= in_byte_i;
    end
    if (cmd_i.rd) begin
      trd_q <= tmem[idx_q[TLW-1:0]];
    end
  end

  assign cnt = run_osc_q ? ITEM_W'(tlen_q) : ITEM_W'(ptot_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.run_start) begin
      idx_q     <= '0;
      run_osc_q <= cmd_i.run_osc;
      fin_q     <= in_byte_i;
    end else if (cmd_i.load_item) begin
      idx_q <= idx_q + ITEM_W'(1);
    end
  end

  assign stat_o.csi_empty = (ptot_q == '0) && !seen_q;
  assign stat_o.osc_empty = (tlen_q == '0);
  assign stat_o.item_last = ((idx_q + ITEM_W'(1)) == cnt);
  assign stat_o.out_free  = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.single || cmd_i.load_item) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.single) begin
      act_q   <= cmd_i.single_act;
      data_q  <= (cmd_i.single_act == ACT_OSC || cmd_i.single_act == ACT_DCS)
               ? 8'd0 : in_byte_i;
      oprv_q  <= (cmd_i.single_act == ACT_CSI) && priv_q;
      oidx_q  <= '0;
      oval_q  <= '0;
      ocnt_q  <= '0;
      olast_q <= 1'b1;
    end else if (cmd_i.load_item) begin
      act_q   <= run_osc_q ? ACT_OSC : ACT_CSI;
      data_q  <= run_osc_q ? trd_q : fin_q;
      oprv_q  <= !run_osc_q && priv_q;
      oidx_q  <= idx_q;
      oval_q  <= run_osc_q ? 16'd0 : prd_q;
      ocnt_q  <= cnt;
      olast_q <= stat_o.item_last;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign action_o       = act_q;
  assign data_byte_o    = data_q;
  assign private_flag_o = oprv_q;
  assign item_index_o   = oidx_q;
  assign param_value_o  = oval_q;
  assign item_count_o   = ocnt_q;
  assign last_o         = olast_q;

endmodule

@@ hw/rtl/ansi_escape_sequence_parser_unit.sv @@
// ----------------------------------------------------------------------------
// ANSI escape sequence parser unit
// VT100/ANSI byte stream parser reporting print, execute, CSI, OSC and DCS.
// ----------------------------------------------------------------------------
// channel   | dir | modport | payload
// byte_i    | in  | sink    | in_byte
// result_o  | out | source  | action, data_byte, private_flag, item_index,
//           |     |         | param_value, item_count, last
//
// One byte is taken per cycle while no result run is in progress.
// Each result of a CSI or OSC run takes a store read, then an output
// register load; input is held off for the whole run.
// A full output register that is not taken holds off both input and runs.
// rst_ni clears the parser to ground and empties the output register.
// ----------------------------------------------------------------------------
module ansi_escape_sequence_parser_unit import aesp_pkg::*; #(
  parameter int unsigned MAX_PARAMS = 16,
  parameter int unsigned OSC_DEPTH  = 64
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  aesp_in_if.sink       byte_i,
  aesp_out_if.source    result_o
);

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  aesp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (byte_i.valid),
    .in_byte_i  (byte_i.in_byte),
    .in_ready_o (byte_i.ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  aesp_dp #(
    .MAX_PARAMS (MAX_PARAMS),
    .OSC_DEPTH  (OSC_DEPTH)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_byte_i      (byte_i.in_byte),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .out_ready_i    (result_o.ready),
    .out_valid_o    (result_o.valid),
    .action_o       (result_o.action),
    .data_byte_o    (result_o.data_byte),
    .private_flag_o (result_o.private_flag),
    .item_index_o   (result_o.item_index),
    .param_value_o  (result_o.param_value),
    .item_count_o   (result_o.item_count),
    .last_o         (result_o.last)
  );

endmodule

@@ hw/rtl/aesp_chk.sv @@
// ----------------------------------------------------------------------------
// ANSI escape parser port checker
// Port-level properties of the parser unit, bound to the top level.
// ----------------------------------------------------------------------------
module aesp_chk import aesp_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [2:0]  action_i,
  input logic [7:0]  data_byte_i,
  input logic [5:0]  item_index_i,
  input logic [15:0] param_value_i,
  input logic [5:0]  item_count_i,
  input logic        last_i
);

  // hold a stalled result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=>
      out_valid_i && $stable(action_i) && $stable(data_byte_i) &&
      $stable(param_value_i) && $stable(item_index_i) && $stable(last_i))
    else $error("stalled result changed");

  // take no byte while a result waits
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |-> !(out_valid_i && !out_ready_i))
    else $error("byte taken while output blocked");

  // only CSI and OSC runs span several results
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !last_i |-> (action_i == ACT_CSI || action_i == ACT_OSC))
    else $error("multi-result run of a single-result action");

  // index and last agree with the run length
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && item_count_i != 6'd0 |->
      item_index_i < item_count_i &&
      last_i == ((item_index_i + 6'd1) == item_count_i))
    else $error("run index out of step with count");

endmodule

bind ansi_escape_sequence_parser_unit aesp_chk u_aesp_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (byte_i.valid),
  .in_ready_i    (byte_i.ready),
  .out_valid_i   (result_o.valid),
  .out_ready_i   (result_o.ready),
  .action_i      (result_o.action),
  .data_byte_i   (result_o.data_byte),
  .item_index_i  (result_o.item_index),
  .param_value_i (result_o.param_value),
  .item_count_i  (result_o.item_count),
  .last_i        (result_o.last)
);
